/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the searchable stack engine.
// No dependencies; each macro expects clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    `ASSERT_CLK(lbl, cond, msg)

`endif

/* hw/rtl/sse_pkg.sv */
// Types and constants of the searchable stack engine.
// No dependencies; used by the top level, its state machine and the testbench.
`timescale 1ns / 1ps

package sse_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;

    localparam int OP_W      = 3;
    localparam int VAL_W     = 32;
    localparam int DEPTH_W   = 4;
    localparam int POS_W     = 4;
    localparam int STS_W     = 3;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_SEARCH     = 3'd2,
        OP_EDIT_VALUE = 3'd3,
        OP_EDIT_DEPTH = 3'd4
    } op_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_FULL      = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_BAD_DEPTH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_HOLD
    } state_t;

endpackage

/* hw/rtl/sse_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/searchable_stack_engine.sv */
// Searchable stack engine: a bounded LIFO of signed 32-bit words held in one
// synchronous RAM (sse_ram), with push, pop, search, edit by value and edit
// by depth. Depends on sse_pkg, sse_ram and assert_macros.svh.
`timescale 1ns / 1ps

// Every request transfer on the slave side produces exactly one result
// transfer on the master side. The operation code travels in s_tuser and the
// status of the result in m_tuser. Requests are handled one at a time. For
// push, edit by depth, any request that fails at once (full, empty, bad
// depth, search or edit by value on an empty stack) and an unknown code, the
// result is registered at the transfer and moves from S_HOLD into the output
// register. For pop it passes through S_POP first, because the top word has
// to come out of the RAM first. Search and edit by value compare one stored
// word per cycle in S_SCAN, from the top down, at most the fill count of
// words (16 at the default depth), before their result reaches S_HOLD. The
// single read port of the stack RAM sets that rate. The next request is taken
// at the edge after the result has moved into the output register. The
// output register may still be waiting for m_tready, so a stalled consumer
// holds the engine off only once a second result is ready. The RAM needs no
// clearing after reset: only words below the fill count are ever read.
module searchable_stack_engine #(
    parameter int STACK_DEPTH = sse_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, lowest bit up: value[31:0], replacement[63:32],
    // depth_from_top[67:64], zero fill[71:68].
    input  logic [sse_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation[2:0].
    input  logic [sse_pkg::OP_W-1:0]      s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, lowest bit up: data_out[31:0], position[35:32],
    // zero fill[39:36].
    output logic [sse_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: status[2:0].
    output logic [sse_pkg::STS_W-1:0]     m_tuser
);

    import sse_pkg::*;

    `include "assert_macros.svh"

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
    localparam int IDX_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;
    localparam int PAD_W  = M_TDATA_W - VAL_W - POS_W;

    // Request fields.
    op_t                 in_op;
    logic [VAL_W-1:0]    in_value;
    logic [VAL_W-1:0]    in_repl;
    logic [DEPTH_W-1:0]  in_depth;
    logic                in_xfer;

    assign in_op    = op_t'(s_tuser);
    assign in_value = s_tdata[VAL_W-1:0];
    assign in_repl  = s_tdata[2*VAL_W-1:VAL_W];
    assign in_depth = s_tdata[2*VAL_W+DEPTH_W-1:2*VAL_W];

    // Control state.
    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    fill_reg,   fill_next;
    logic [ADDR_W-1:0]   idx_reg,    idx_next;
    op_t                 op_reg,     op_next;
    logic [VAL_W-1:0]    key_reg,    key_next;
    logic [VAL_W-1:0]    repl_reg,   repl_next;

    // Result waiting for the output register.
    logic [VAL_W-1:0]    res_data_reg, res_data_next;
    logic [POS_W-1:0]    res_pos_reg,  res_pos_next;
    status_t             res_sts_reg,  res_sts_next;

    // Output register.
    logic                m_valid_reg;
    logic [VAL_W-1:0]    m_data_reg;
    logic [POS_W-1:0]    m_pos_reg;
    status_t             m_sts_reg;
    logic                out_load;

    // RAM ports.
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [VAL_W-1:0]    wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [VAL_W-1:0]    rd_data;

    // Helpers derived from the fill count.
    logic [CNT_W-1:0]    fill_m1;
    logic [CMP_W-1:0]    fill_ext;
    logic [CMP_W-1:0]    depth_ext;
    logic [CMP_W-1:0]    edit_addr;
    logic [IDX_W-1:0]    idx_ext;
    logic                is_full;
    logic                is_empty;

    assign fill_m1   = fill_reg - CNT_W'(1);
    assign fill_ext  = CMP_W'(fill_reg);
    assign depth_ext = CMP_W'(in_depth);
    assign edit_addr = fill_ext - CMP_W'(1) - depth_ext;
    assign idx_ext   = IDX_W'(idx_reg);
    assign is_full   = (fill_reg == CNT_W'(STACK_DEPTH));
    assign is_empty  = (fill_reg == '0);

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_HOLD) && (!m_valid_reg || m_tready);

    sse_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        key_reg      <= key_next;
        repl_reg     <= repl_next;
        res_data_reg <= res_data_next;
        res_pos_reg  <= res_pos_next;
        res_sts_reg  <= res_sts_next;
        if (out_load)
        begin
            m_data_reg <= res_data_reg;
            m_pos_reg  <= res_pos_reg;
            m_sts_reg  <= res_sts_reg;
        end
    end

    // A write and a read of the same word never fall in the same cycle, and
    // a new request is taken only after the engine has left S_HOLD, never in
    // the cycle of the last write, so the RAM needs no forwarding path.
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        repl_next     = repl_reg;
        res_data_next = res_data_reg;
        res_pos_next  = res_pos_reg;
        res_sts_next  = res_sts_reg;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[ADDR_W-1:0];
        wr_data       = in_value;
        rd_en         = 1'b0;
        rd_addr       = fill_m1[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next       = in_op;
                    key_next      = in_value;
                    repl_next     = in_repl;
                    res_data_next = '0;
                    res_pos_next  = '0;
                    res_sts_next  = STS_OK;
                    state_next    = S_HOLD;
                    case (in_op)
                        OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_sts_next = STS_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                res_sts_next = STS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                fill_next  = fill_m1;
                                state_next = S_POP;
                            end
                        end
                        OP_SEARCH, OP_EDIT_VALUE:
                        begin
                            if (is_empty)
                            begin
                                res_sts_next = STS_NOT_FOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                idx_next   = fill_m1[ADDR_W-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        OP_EDIT_DEPTH:
                        begin
                            if (depth_ext >= fill_ext)
                            begin
                                res_sts_next = STS_BAD_DEPTH;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = edit_addr[ADDR_W-1:0];
                                wr_data = in_repl;
                            end
                        end
                        default:
                        begin
                            // Unknown codes change nothing and answer zeros.
                            res_sts_next = STS_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_data_next = rd_data;
                state_next    = S_HOLD;
            end
            S_SCAN:
            begin
                // rd_data holds the word at idx_reg; fetch the one below it.
                rd_addr = idx_reg - ADDR_W'(1);
                if (rd_data == key_reg)
                begin
                    state_next = S_HOLD;
                    if (op_reg == OP_EDIT_VALUE)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = repl_reg;
                    end
                    else
                    begin
                        res_pos_next = idx_ext[POS_W-1:0];
                    end
                end
                else if (idx_reg == '0)
                begin
                    res_sts_next = STS_NOT_FOUND;
                    state_next   = S_HOLD;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg - ADDR_W'(1);
                end
            end
            S_HOLD:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_pos_reg, m_data_reg};
    assign m_tuser  = m_sts_reg;

    `ASSERT_ALWAYS(a_fill_bounded, fill_reg <= CNT_W'(STACK_DEPTH),
        "fill count exceeds the stack depth")
    `ASSERT_CLK(a_fill_only_on_request, !in_xfer |=> $stable(fill_reg),
        "fill count changed without a request transfer")
    `ASSERT_CLK(a_scan_below_fill, (state_reg == S_SCAN) |-> (CNT_W'(idx_reg) < fill_reg),
        "scan index at or above the fill count")
    `ASSERT_CLK(a_scan_write_edit, (state_reg == S_SCAN && wr_en) |-> (op_reg == OP_EDIT_VALUE),
        "RAM written during a search")

endmodule

/* sim/tb_searchable_stack_engine.sv */
// Self-checking testbench for the searchable stack engine: a queue-fed stream
// driver, a stream monitor and an internal stack predictor checking every reply.
// Depends on sse_pkg and the searchable_stack_engine RTL.
`timescale 1ns / 1ps

module tb_searchable_stack_engine;

    import sse_pkg::*;

    localparam int STACK_WORDS = DEFAULT_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [OP_W-1:0] OP_CODE_MAX = 3'd7;

    typedef struct {
        logic [OP_W-1:0]    op_code;
        logic [VAL_W-1:0]   value;
        logic [VAL_W-1:0]   replacement;
        logic [DEPTH_W-1:0] depth;
        int                 phase;
        bit                 drain_first;
    } stack_request_t;

    typedef struct {
        logic [VAL_W-1:0] data;
        logic [POS_W-1:0] position;
        logic [STS_W-1:0] status;
    } stack_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STS_W-1:0]     m_tuser;

    stack_request_t request_queue[$];
    stack_reply_t   reply_queue[$];
    stack_request_t on_bus;

    // Predictor state: the stored words and how many of them are live.
    logic [VAL_W-1:0] stack_mem[STACK_WORDS];
    int               stack_fill = 0;

    int gen_fill = 0;
    int n_sent = 0;
    int n_checked = 0;
    int cur_phase = 0;
    int error_count = 0;
    int cycle_count = 0;
    logic [VAL_W-1:0] value_pool[8];

    searchable_stack_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Percentage of cycles in which one side idles, per phase of the run.
    function automatic int idle_pct(input int ph, input bit sender);
        case (ph)
            0: return sender ? 14 : 73;
            1: return sender ? 73 : 14;
            default: return 0;
        endcase
    endfunction

    // Applies one request to the predictor's stack and returns the reply.
    function automatic stack_reply_t compute_stack_reply(input stack_request_t req);
        stack_reply_t rep;
        int hit;
        hit = -1;
        rep.data = '0;
        rep.position = '0;
        rep.status = STS_OK;
        if (req.op_code == OP_SEARCH || req.op_code == OP_EDIT_VALUE)
        begin
            for (int i = stack_fill - 1; i >= 0; i--)
            begin
                if (stack_mem[i] == req.value)
                begin
                    hit = i;
                    break;
                end
            end
        end
        case (req.op_code)
            OP_PUSH:
            begin
                if (stack_fill >= STACK_WORDS)
                    rep.status = STS_FULL;
                else
                begin
                    stack_mem[stack_fill] = req.value;
                    stack_fill++;
                end
            end
            OP_POP:
            begin
                if (stack_fill == 0)
                    rep.status = STS_EMPTY;
                else
                begin
                    stack_fill--;
                    rep.data = stack_mem[stack_fill];
                end
            end
            OP_SEARCH:
            begin
                if (hit < 0)
                    rep.status = STS_NOT_FOUND;
                else
                    rep.position = hit[POS_W-1:0];
            end
            OP_EDIT_VALUE:
            begin
                if (hit < 0)
                    rep.status = STS_NOT_FOUND;
                else
                    stack_mem[hit] = req.replacement;
            end
            OP_EDIT_DEPTH:
            begin
                if (int'(req.depth) >= stack_fill)
                    rep.status = STS_BAD_DEPTH;
                else
                    stack_mem[stack_fill - 1 - int'(req.depth)] = req.replacement;
            end
            default:
            begin
                // Unused operation codes leave the stack alone and answer with zeros.
            end
        endcase
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        $display("%0t ns reply %0d: %s is %0h, expected %0h", $time, n_checked, what,
                 got, wanted);
        error_count++;
    endtask

    // Queues a request and tracks the fill level it leaves, so that the
    // random part can steer the stack between empty and full.
    task automatic queue_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                                 input logic [VAL_W-1:0] rep,
                                 input logic [DEPTH_W-1:0] depth, input int ph,
                                 input bit drain);
        stack_request_t req;
        req.op_code = op;
        req.value = val;
        req.replacement = rep;
        req.depth = depth;
        req.phase = ph;
        req.drain_first = drain;
        request_queue.push_back(req);
        if (op == OP_PUSH && gen_fill < STACK_WORDS)
            gen_fill++;
        else if (op == OP_POP && gen_fill > 0)
            gen_fill--;
    endtask

    function automatic logic [VAL_W-1:0] pick_word(input int pool_pct);
        if ($urandom_range(99) < pool_pct)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Driver: a new transfer may be offered whenever the bus is free or the
    // current one completes at this edge; valid is held until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reply_queue.push_back(compute_stack_reply(on_bus));
                n_sent = n_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() > 0
                    && !(request_queue[0].drain_first && n_checked < n_sent)
                    && $urandom_range(99) >= idle_pct(request_queue[0].phase, 1'b1))
                begin
                    on_bus = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(S_TDATA_W - 2 * VAL_W - DEPTH_W){1'b0}}, on_bus.depth,
                                on_bus.replacement, on_bus.value};
                    s_tuser <= on_bus.op_code;
                    cur_phase <= on_bus.phase;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, and each reply checked against the
    // oldest prediction field by field.
    always @(posedge clk or negedge rst_n)
    begin
        stack_reply_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b0));
            if (m_tvalid && m_tready)
            begin
                if (reply_queue.size() == 0)
                    report_mismatch("reply with none pending, data_out",
                                    m_tdata[VAL_W-1:0], '0);
                else
                begin
                    want = reply_queue.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want.data)
                        report_mismatch("data_out", m_tdata[VAL_W-1:0], want.data);
                    if (m_tdata[VAL_W+POS_W-1:VAL_W] !== want.position)
                        report_mismatch("position", 32'(m_tdata[VAL_W+POS_W-1:VAL_W]),
                                        32'(want.position));
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                end
                n_checked <= n_checked + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int r;
        bit filling;
        logic [OP_W-1:0] op;
        logic [DEPTH_W-1:0] dep;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // Directed part: failures on an empty stack, the extreme words,
        // duplicates so that the topmost match matters, depth beyond the
        // fill level, and the unused operation codes.
        queue_request(OP_POP, '0, '0, '0, 0, 1'b1);
        queue_request(OP_SEARCH, '0, '0, '0, 0, 1'b0);
        queue_request(OP_EDIT_VALUE, '0, 32'h1, '0, 0, 1'b0);
        queue_request(OP_EDIT_DEPTH, '0, 32'h1, '0, 0, 1'b0);
        queue_request(OP_PUSH, 32'h8000_0000, '0, '0, 0, 1'b0);
        queue_request(OP_PUSH, 32'h7fff_ffff, '0, '0, 0, 1'b0);
        queue_request(OP_PUSH, 32'h0000_0000, '0, '0, 0, 1'b0);
        queue_request(OP_PUSH, 32'hffff_ffff, '0, '0, 0, 1'b0);
        queue_request(OP_PUSH, 32'h7fff_ffff, '0, '0, 0, 1'b0);
        queue_request(OP_SEARCH, 32'h7fff_ffff, '0, '0, 0, 1'b0);
        queue_request(OP_SEARCH, 32'h1234_5678, '0, '0, 0, 1'b0);
        queue_request(OP_EDIT_VALUE, 32'h7fff_ffff, 32'h8000_0000, '0, 0, 1'b0);
        queue_request(OP_SEARCH, 32'h7fff_ffff, '0, '0, 0, 1'b0);
        queue_request(OP_EDIT_DEPTH, '0, 32'h5555_aaaa, 4'hf, 0, 1'b0);
        queue_request(OP_EDIT_DEPTH, '0, 32'hffff_ffff, 4'd4, 0, 1'b0);
        queue_request(OP_EDIT_DEPTH, '0, 32'h7fff_ffff, 4'd0, 0, 1'b0);
        for (int c = OP_EDIT_DEPTH + 1; c <= OP_CODE_MAX; c++)
            queue_request(c[OP_W-1:0], 32'hffff_ffff, 32'hffff_ffff, 4'hf, 0, 1'b0);
        queue_request(OP_POP, '0, '0, '0, 0, 1'b0);
        queue_request(OP_POP, '0, '0, '0, 0, 1'b0);
        queue_request(OP_SEARCH, 32'hffff_ffff, '0, '0, 0, 1'b0);

        // Random part: the operation mix swings between filling and
        // draining so that the stack keeps running from empty to full.
        filling = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            ph = (i * 3) / RANDOM_ITEMS;
            if (gen_fill >= STACK_WORDS)
                filling = 1'b0;
            else if (gen_fill == 0)
                filling = 1'b1;
            r = $urandom_range(99);
            if (r < (filling ? 40 : 10))
                op = OP_PUSH;
            else if (r < 50)
                op = OP_POP;
            else if (r < 70)
                op = OP_SEARCH;
            else if (r < 82)
                op = OP_EDIT_VALUE;
            else if (r < 95)
                op = OP_EDIT_DEPTH;
            else
                op = OP_W'($urandom_range(OP_CODE_MAX, OP_EDIT_DEPTH + 1));
            if (gen_fill > 0 && $urandom_range(99) < 75)
                dep = DEPTH_W'($urandom_range(gen_fill - 1));
            else
                dep = DEPTH_W'($urandom_range(15));
            queue_request(op, pick_word(op == OP_PUSH ? 70 : 80), pick_word(50), dep, ph,
                          (i * 3) % RANDOM_ITEMS < 3 || $urandom_range(99) < 2);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (request_queue.size() == 0 && !s_tvalid && n_checked >= n_sent);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (reply_queue.size() != 0)
            report_mismatch("replies never returned", 32'(reply_queue.size()), '0);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* searchable_stack_engine.f */
+incdir+hw/rtl
hw/rtl/sse_pkg.sv
hw/rtl/sse_ram.sv
hw/rtl/searchable_stack_engine.sv
sim/tb_searchable_stack_engine.sv
